>>> hw/rtl/pfad_pkg.sv
package pfad_pkg;

	localparam int DIR_ENTRIES = 1024;
	localparam int DIR_IDX_W   = 10;
	localparam int ENTRY_W     = 15;
	localparam int WORD_BITS   = 32;

	localparam logic [DIR_IDX_W-1:0] KERNEL_HIGH = 10'h300;

	// entry flag bits: present, writable, user, reserved, 4 MB page
	localparam logic [4:0] FLAGS_KERNEL = 5'h13;
	localparam logic [4:0] FLAGS_USER   = 5'h17;
	localparam logic [ENTRY_W-1:0] ENTRY_KERNEL = {10'd0, FLAGS_KERNEL};
	localparam logic [ENTRY_W-1:0] ENTRY_EMPTY  = '0;

	typedef enum logic [1:0] {
		ACT_CHECK = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2,
		ACT_NOP   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_FRAME  = 2'd1,
		STS_UNMAPPED  = 2'd2,
		STS_NOT_ENOUGH = 2'd3
	} sts_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic clear_step;
		logic scan_step;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		act_t in_action;
		logic clear_last;
		logic scan_hit;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

>>> hw/rtl/pfad_if.sv
interface pfad_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  dir_index;
	logic [31:0] amount;

	modport source (output valid, action, dir_index, amount, input ready);
	modport sink (input valid, action, dir_index, amount, output ready);
endinterface

interface pfad_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] frame;
	logic [5:0] free_frames;
	logic       flush_valid;
	logic [9:0] flush_index;

	modport source (output valid, status, frame, free_frames, flush_valid, flush_index,
		input ready);
	modport sink (input valid, status, frame, free_frames, flush_valid, flush_index,
		output ready);
endinterface

>>> hw/rtl/page_frame_allocator_with_directory_top.sv
// Page frame allocator with a 1024-entry page directory of 4 MB entries.
// req channel: one word per request (action, dir_index, amount).
//   check    - compares the rounded-up frame count of amount with free frames
//   allocate - maps the lowest free frame at dir_index, asks for a TLB flush
//   free     - releases the frame of a present entry and clears the entry
// rsp channel: one word per request (status, frame, free_frames, flush).
// Check, free and the unused code go from the accept to the execute step,
// which writes the response into the output register; allocate first scans
// the frame bitmap one 32-bit word per cycle, at most ceil(FRAME_COUNT/32)
// words, up to the first word with a free frame. Free reads the entry from
// the directory RAM in the accept cycle and updates it in the execute step.
// One request is in flight at a time; req.ready drops while it is worked on.
// After reset the directory RAM is swept over all 1024 entries (kernel entries
// 0 and 0x300 written, the rest cleared) with req.ready low; frame 0 starts
// reserved. The response sits in an output register, so req.ready returns
// while a response is still waiting; if rsp stalls, the next request is
// held at its final step until the register frees up.
module page_frame_allocator_with_directory_top
	import pfad_pkg::*;
#(
	parameter int FRAME_COUNT = 32,
	parameter int FRAME_SHIFT = 22
) (
	input  logic       clk,
	input  logic       arst_n,
	pfad_req_if.sink   req,
	pfad_rsp_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;

	pfad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	pfad_dp #(
		.FRAME_COUNT (FRAME_COUNT),
		.FRAME_SHIFT (FRAME_SHIFT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> hw/rtl/pfad_ctrl.sv
module pfad_ctrl
	import pfad_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					state_d = (stat.in_action == ACT_ALLOC) ? ST_SCAN : ST_EXEC;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_hit || stat.scan_last) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait here until the output register can take the word
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

>>> hw/rtl/pfad_dp.sv
module pfad_dp
	import pfad_pkg::*;
#(
	parameter int FRAME_COUNT = 32,
	parameter int FRAME_SHIFT = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output stat_t         stat,
	pfad_req_if.sink      req,
	pfad_rsp_if.source    rsp
);

	localparam int FRAME_W   = $clog2(FRAME_COUNT);
	localparam int CNT_W     = $clog2(FRAME_COUNT + 1);
	localparam int NUM_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam logic [31:0] LOW_MASK = (32'd1 << FRAME_SHIFT) - 32'd1;

	// request registers
	act_t                 action_q;
	logic [DIR_IDX_W-1:0] idx_q;
	logic [31:0]          amount_q;

	// allocation state
	logic [FRAME_COUNT-1:0] map_q;
	logic [CNT_W-1:0]       count_q;

	// scan
	logic [WORD_W-1:0]  scan_w_q;
	logic [FRAME_W-1:0] found_q;
	logic               found_hit_q;
	logic [NUM_WORDS*WORD_BITS-1:0] map_pad;
	logic [WORD_BITS-1:0] scan_word;
	logic [4:0]           scan_pos;
	logic [31:0]          found_full;

	// directory memory
	logic [ENTRY_W-1:0]   dir_mem [DIR_ENTRIES];
	logic [ENTRY_W-1:0]   rd_q;
	logic [DIR_IDX_W-1:0] rd_addr;
	logic [DIR_IDX_W-1:0] clr_q;
	logic                 we;
	logic [DIR_IDX_W-1:0] wa;
	logic [ENTRY_W-1:0]   wd;

	// output register
	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic [4:0] out_frame_q;
	logic [5:0] out_free_q;
	logic       out_flush_q;
	logic [9:0] out_fidx_q;

	// execute-step results
	logic                 accept;
	logic [32:0]          needed;
	logic                 present;
	logic [DIR_IDX_W-1:0] fno;
	logic                 fno_in_range;
	logic                 releasable;
	logic [CNT_W-1:0]     count_d;
	logic [FRAME_COUNT-1:0] map_d;
	sts_t                 sts_d;
	logic [31:0]          frame_d;
	logic                 flush_d;
	logic [31:0]          count_ext;

	assign accept = cmd.in_ready && req.valid;
	assign req.ready = cmd.in_ready;

	assign stat.in_valid   = req.valid;
	assign stat.in_action  = act_t'(req.action);
	assign stat.clear_last = (clr_q == '1);
	assign stat.out_free   = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= act_t'(req.action);
			idx_q    <= req.dir_index;
			amount_q <= req.amount;
		end
	end

	// ---- lowest free frame, one 32-bit word per cycle
	always_comb begin
		map_pad = '1;
		map_pad[FRAME_COUNT-1:0] = map_q;
	end

	assign scan_word = map_pad[scan_w_q*WORD_BITS +: WORD_BITS];

	always_comb begin
		scan_pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!scan_word[i]) begin
				scan_pos = 5'(i);
			end
		end
	end

	assign stat.scan_hit  = ~&scan_word;
	assign stat.scan_last = (scan_w_q == WORD_W'(NUM_WORDS - 1));
	assign found_full = (32'(scan_w_q) << 5) | 32'(scan_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_w_q    <= '0;
			found_hit_q <= 1'b0;
		end else if (accept) begin
			scan_w_q    <= '0;
			found_hit_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (stat.scan_hit) begin
				found_hit_q <= 1'b1;
			end else if (!stat.scan_last) begin
				scan_w_q <= scan_w_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && stat.scan_hit) begin
			found_q <= found_full[FRAME_W-1:0];
		end
	end

	// ---- execute step
	always_comb begin
		needed = {1'b0, amount_q >> FRAME_SHIFT} + 33'(|(amount_q & LOW_MASK));
		present = rd_q[0];
		fno = rd_q[ENTRY_W-1:5];
		fno_in_range = (32'(fno) < FRAME_COUNT);
		releasable = fno_in_range && map_q[fno[FRAME_W-1:0]];
		count_d = count_q;
		map_d = map_q;
		sts_d = STS_OK;
		frame_d = '0;
		flush_d = 1'b0;
		we = 1'b0;
		wa = idx_q;
		wd = ENTRY_EMPTY;
		case (action_q)
			ACT_CHECK: begin
				sts_d = (33'(count_q) >= needed) ? STS_OK : STS_NOT_ENOUGH;
			end
			ACT_ALLOC: begin
				if (!found_hit_q) begin
					sts_d = STS_NO_FRAME;
				end else begin
					map_d[found_q] = 1'b1;
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
					frame_d = 32'(found_q);
					flush_d = 1'b1;
					we = cmd.exec;
					wd = {10'(found_q), FLAGS_USER};
				end
			end
			ACT_FREE: begin
				if (!present) begin
					sts_d = STS_UNMAPPED;
				end else begin
					if (releasable) begin
						map_d[fno[FRAME_W-1:0]] = 1'b0;
						count_d = count_q + 1'b1;
					end
					frame_d = 32'(fno);
					flush_d = 1'b1;
					we = cmd.exec;
				end
			end
			default: begin
				sts_d = STS_OK;
			end
		endcase
		// reset sweep: kernel entries get their fixed mapping
		if (cmd.clear_step) begin
			we = 1'b1;
			wa = clr_q;
			wd = (clr_q == '0 || clr_q == KERNEL_HIGH) ? ENTRY_KERNEL : ENTRY_EMPTY;
		end
		count_ext = 32'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= FRAME_COUNT'(1);
			count_q <= CNT_W'(FRAME_COUNT - 1);
		end else if (cmd.exec) begin
			map_q   <= map_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// ---- directory memory, registered read
	assign rd_addr = cmd.in_ready ? req.dir_index : idx_q;

	always_ff @(posedge clk) begin
		if (we) begin
			dir_mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= dir_mem[rd_addr];
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status_q <= sts_d;
			out_frame_q  <= frame_d[4:0];
			out_free_q   <= count_ext[5:0];
			out_flush_q  <= flush_d;
			out_fidx_q   <= flush_d ? idx_q : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.frame       = out_frame_q;
	assign rsp.free_frames = out_free_q;
	assign rsp.flush_valid = out_flush_q;
	assign rsp.flush_index = out_fidx_q;

endmodule

>>> test/tb_page_frame_allocator_with_directory_top.sv
module tb_page_frame_allocator_with_directory_top;
	import pfad_pkg::*;

	localparam int FRAMES = 32;
	localparam int SHIFT = 22;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WORDS_PER_PHASE = 633;

	typedef struct packed {
		sts_t                 status;
		logic [4:0]           frame;
		logic [5:0]           free_frames;
		logic                 flush_valid;
		logic [DIR_IDX_W-1:0] flush_index;
	} frame_rsp_t;

	typedef struct packed {
		bit         typed;
		frame_rsp_t rsp;
	} staged_t;

	typedef struct packed {
		act_t                 act;
		logic [DIR_IDX_W-1:0] idx;
		logic [31:0]          amt;
		logic [6:0]           reps;
		bit                   typed;
		frame_rsp_t           rsp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	pfad_req_if req_if ();
	pfad_rsp_if rsp_if ();

	page_frame_allocator_with_directory_top #(
		.FRAME_COUNT(FRAMES),
		.FRAME_SHIFT(SHIFT)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if.sink),
		.rsp   (rsp_if.source)
	);

	// shadow of the allocator state
	bit                 frame_busy [FRAMES];
	int                 free_left;
	logic [ENTRY_W-1:0] pdir [DIR_ENTRIES];

	staged_t    staged_q [$];
	frame_rsp_t pending_rsp [$];
	dir_row_t   dir_rows [$];

	int src_gap = 27;
	int sink_gap = 64;
	int errors = 0;
	int cycles = 0;
	int words_by_act [4];
	int rsp_seen = 0;
	int refused = 0;
	int unmapped = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles,
				pending_rsp.size());
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) rsp_if.ready <= ($urandom_range(99) >= sink_gap);

	function automatic void reset_shadow();
		for (int i = 0; i < FRAMES; i++) frame_busy[i] = 1'b0;
		frame_busy[0] = 1'b1;
		free_left = FRAMES - 1;
		for (int i = 0; i < DIR_ENTRIES; i++) pdir[i] = ENTRY_EMPTY;
		pdir[0] = ENTRY_KERNEL;
		pdir[KERNEL_HIGH] = ENTRY_KERNEL;
	endfunction

	function automatic frame_rsp_t apply_request(act_t act, logic [DIR_IDX_W-1:0] idx,
		logic [31:0] amt);
		frame_rsp_t r;
		logic [31:0] lowmask;
		int need;
		int hit;
		logic [9:0] fno;
		r = '0;
		r.status = STS_OK;
		case (act)
			ACT_CHECK: begin
				lowmask = (32'd1 << SHIFT) - 32'd1;
				need = int'(amt >> SHIFT) + ((amt & lowmask) != 0 ? 1 : 0);
				r.status = (free_left >= need) ? STS_OK : STS_NOT_ENOUGH;
			end
			ACT_ALLOC: begin
				hit = -1;
				for (int i = FRAMES - 1; i >= 0; i--) if (!frame_busy[i]) hit = i;
				if (hit < 0) begin
					r.status = STS_NO_FRAME;
				end else begin
					frame_busy[hit] = 1'b1;
					pdir[idx] = {10'(hit), FLAGS_USER};
					if (free_left > 0) free_left--;
					r.frame = 5'(hit);
					r.flush_valid = 1'b1;
					r.flush_index = idx;
				end
			end
			ACT_FREE: begin
				fno = pdir[idx][ENTRY_W-1:5];
				if (!pdir[idx][0]) begin
					r.status = STS_UNMAPPED;
				end else begin
					// no double release, and out-of-range frames leave the map alone
					if (fno < FRAMES && frame_busy[fno]) begin
						frame_busy[fno] = 1'b0;
						free_left++;
					end
					pdir[idx] = ENTRY_EMPTY;
					r.frame = fno[4:0];
					r.flush_valid = 1'b1;
					r.flush_index = idx;
				end
			end
			default: ;
		endcase
		r.free_frames = 6'(free_left);
		return r;
	endfunction

	// response check first, then the request accepted at the same edge
	always @(posedge clk) begin
		frame_rsp_t got;
		frame_rsp_t want;
		staged_t st;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.status = sts_t'(rsp_if.status);
				got.frame = rsp_if.frame;
				got.free_frames = rsp_if.free_frames;
				got.flush_valid = rsp_if.flush_valid;
				got.flush_index = rsp_if.flush_index;
				rsp_seen++;
				if (pending_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected response word sts=%0d frame=%0d free=%0d flush=%0b/%0d",
						$time, got.status, got.frame, got.free_frames, got.flush_valid,
						got.flush_index);
				end else begin
					want = pending_rsp.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: expected sts=%0d frame=%0d free=%0d flush=%0b/%0d, got sts=%0d frame=%0d free=%0d flush=%0b/%0d",
							$time, want.status, want.frame, want.free_frames, want.flush_valid,
							want.flush_index, got.status, got.frame, got.free_frames,
							got.flush_valid, got.flush_index);
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				st = staged_q.pop_front();
				want = apply_request(act_t'(req_if.action), req_if.dir_index, req_if.amount);
				words_by_act[req_if.action]++;
				if (want.status == STS_NO_FRAME) refused++;
				if (want.status == STS_UNMAPPED) unmapped++;
				pending_rsp.push_back(st.typed ? st.rsp : want);
			end
		end
	end

	// called at a rising edge; valid stays high after acceptance until the next gap
	task automatic send_word(act_t act, logic [DIR_IDX_W-1:0] idx, logic [31:0] amt,
		bit typed, frame_rsp_t rsp);
		staged_t st;
		while ($urandom_range(99) < src_gap) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		st.typed = typed;
		st.rsp = rsp;
		staged_q.push_back(st);
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.dir_index <= idx;
		req_if.amount <= amt;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (staged_q.size() != 0 || pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(act_t a, logic [DIR_IDX_W-1:0] i, logic [31:0] m, int n, bit t,
		frame_rsp_t e);
		dir_row_t row;
		row.act = a;
		row.idx = i;
		row.amt = m;
		row.reps = 7'(n);
		row.typed = t;
		row.rsp = e;
		dir_rows.push_back(row);
	endtask

	initial begin
		dir_row_t row;
		act_t act;
		logic [DIR_IDX_W-1:0] idx;
		logic [31:0] amt;
		int r;
		int k;
		req_if.valid = 1'b0;
		req_if.action = ACT_CHECK;
		req_if.dir_index = '0;
		req_if.amount = '0;
		rsp_if.ready = 1'b0;
		arst_n = 1'b0;
		reset_shadow();
		foreach (words_by_act[i]) words_by_act[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		add_row(ACT_CHECK, 0, 32'h0, 1, 1, '{STS_OK, 5'd0, 6'd31, 1'b0, 10'd0});
		add_row(ACT_CHECK, 0, 32'hFFFF_FFFF, 1, 1, '{STS_NOT_ENOUGH, 5'd0, 6'd31, 1'b0, 10'd0});
		add_row(ACT_CHECK, 0, 32'h07C0_0000, 1, 0, '0);
		add_row(ACT_CHECK, 0, 32'h07C0_0001, 1, 0, '0);
		add_row(ACT_FREE, 1, 32'h0, 1, 1, '{STS_UNMAPPED, 5'd0, 6'd31, 1'b0, 10'd0});
		add_row(ACT_ALLOC, 1023, 32'h0, 1, 1, '{STS_OK, 5'd1, 6'd30, 1'b1, 10'd1023});
		// overwrite the upper kernel entry, then release it and the reserved frame
		add_row(ACT_ALLOC, KERNEL_HIGH, 32'h0, 1, 0, '0);
		add_row(ACT_FREE, KERNEL_HIGH, 32'h0, 1, 0, '0);
		add_row(ACT_FREE, 0, 32'h0, 1, 0, '0);
		add_row(ACT_NOP, 1023, 32'hFFFF_FFFF, 1, 1, '{STS_OK, 5'd0, 6'd31, 1'b0, 10'd0});
		add_row(ACT_ALLOC, 0, 32'h0, 1, 0, '0);
		add_row(ACT_ALLOC, 16, 32'h0, 32, 0, '0);
		add_row(ACT_CHECK, 0, 32'h0, 1, 0, '0);
		add_row(ACT_CHECK, 0, 32'h1, 1, 0, '0);
		add_row(ACT_ALLOC, 5, 32'h0, 1, 1, '{STS_NO_FRAME, 5'd0, 6'd0, 1'b0, 10'd0});
		add_row(ACT_FREE, KERNEL_HIGH, 32'h0, 1, 0, '0);
		add_row(ACT_FREE, 1023, 32'h0, 2, 0, '0);
		add_row(ACT_CHECK, 0, 32'h0040_0000, 1, 0, '0);
		add_row(ACT_FREE, 16, 32'h0, 32, 0, '0);
		add_row(ACT_ALLOC, 1023, 32'h0, 2, 0, '0);
		add_row(ACT_FREE, 1023, 32'h0, 1, 0, '0);
		add_row(ACT_CHECK, 0, 32'hFFC0_0000, 1, 0, '0);

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			for (k = 0; k < row.reps; k++)
				send_word(row.act, row.idx + 10'(k), row.amt, row.typed, row.rsp);
		end
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			src_gap = (phase == 0) ? 27 : (phase == 1) ? 64 : 0;
			sink_gap = (phase == 0) ? 64 : (phase == 1) ? 27 : 0;
			repeat (WORDS_PER_PHASE) begin
				r = $urandom_range(99);
				act = (r < 35) ? ACT_ALLOC : (r < 75) ? ACT_FREE : (r < 92) ? ACT_CHECK : ACT_NOP;
				r = $urandom_range(99);
				if (r < 60)
					idx = 10'($urandom_range(47));
				else if (r < 72)
					idx = ($urandom_range(1) != 0) ? KERNEL_HIGH : 10'd1023;
				else
					idx = 10'($urandom);
				r = $urandom_range(99);
				if (r < 40) begin
					amt = $urandom;
				end else if (r < 45) begin
					amt = 32'hFFFF_FFFF;
				end else begin
					// near a frame boundary
					amt = 32'($urandom_range(34)) << SHIFT;
					case ($urandom_range(3))
						0: ;
						1: amt = amt + 32'd1;
						2: amt = amt - 32'd1;
						default: amt = amt + 32'($urandom_range((1 << SHIFT) - 1));
					endcase
				end
				send_word(act, idx, amt, 0, '0);
			end
			drain();
		end
		repeat (12) @(posedge clk);

		$display("%0d words: %0d check, %0d allocate, %0d free, %0d unused code; %0d responses",
			words_by_act[ACT_CHECK] + words_by_act[ACT_ALLOC] + words_by_act[ACT_FREE]
			+ words_by_act[ACT_NOP], words_by_act[ACT_CHECK], words_by_act[ACT_ALLOC],
			words_by_act[ACT_FREE], words_by_act[ACT_NOP], rsp_seen);
		$display("%0d allocations refused with frames exhausted, %0d frees of unmapped entries",
			refused, unmapped);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/pfad_pkg.sv
hw/rtl/pfad_if.sv
hw/rtl/pfad_ctrl.sv
hw/rtl/pfad_dp.sv
hw/rtl/page_frame_allocator_with_directory_top.sv
test/tb_page_frame_allocator_with_directory_top.sv
